@@ rtl/ctsc_pkg.sv @@
// shared types, codes and constants of the text console
package ctsc_pkg;

   localparam int DEF_NUM_ROWS = 25;
   localparam int DEF_NUM_COLS = 80;

   localparam int CELL_W = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] TEXT_ATTR_RESET = 8'h0F;
   localparam logic [7:0] BLANK_ATTR_RESET = 8'h00;

   typedef enum logic [1:0] {
      CMD_PUT   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TEXT_ATTR  = 1'b0,
      CSR_BLANK_ATTR = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_IDLE,
      ST_EXEC,
      ST_SCROLL,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      cmd_type     command;
      logic [7:0]  char_code;
      logic [10:0] read_address;
   } req_item_type;

   typedef struct packed {
      logic [15:0] cell_value;
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
   } rsp_item_type;

endpackage

@@ rtl/ctsc_ram.sv @@
// cell store: one write port, one registered read port
module ctsc_ram import ctsc_pkg::*; #(
   parameter int DEPTH = DEF_NUM_ROWS * DEF_NUM_COLS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [CELL_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [CELL_W-1:0]        rd_data
);

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/ctsc_ctrl.sv @@
// command sequencer: cursor, put, scroll copy, blank fill and cell read
module ctsc_ctrl import ctsc_pkg::*; #(
   parameter int NUM_ROWS = DEF_NUM_ROWS,
   parameter int NUM_COLS = DEF_NUM_COLS,
   localparam int CELLS = NUM_ROWS * NUM_COLS,
   localparam int AW = $clog2(CELLS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_item_type      req_item,
   output logic              rsp_valid,
   output rsp_item_type      rsp_item,
   input  logic [7:0]        text_attr,
   input  logic [7:0]        blank_attr,
   output logic              mem_wr_en,
   output logic [AW-1:0]     mem_wr_addr,
   output logic [CELL_W-1:0] mem_wr_data,
   output logic [AW-1:0]     mem_rd_addr,
   input  logic [CELL_W-1:0] mem_rd_data
);

   localparam int RW = $clog2(NUM_ROWS);
   localparam int CW = $clog2(NUM_COLS);
   localparam int KEEP = (NUM_ROWS - 1) * NUM_COLS;

   state_type         state_ff, state_in;
   logic [AW-1:0]     cnt_ff, cnt_in;
   logic              pend_ff, pend_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0] fill_word_ff, fill_word_in;
   logic              fill_resp_ff, fill_resp_in;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [CELL_W-1:0] cell_ff, cell_in;
   req_item_type      req_ff, req_in;

   logic [AW-1:0]     put_addr;
   logic [31:0]       row_wide;
   logic [31:0]       col_wide;
   logic              rd_in_range;

   assign put_addr = AW'(AW'(row_ff) * AW'(NUM_COLS) + AW'(col_ff));
   assign rd_in_range = 32'(req_ff.read_address) < 32'(CELLS);
   assign row_wide = 32'(row_ff);
   assign col_wide = 32'(col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         fill_word_ff <= {8'h00, CHAR_SPACE};
         fill_resp_ff <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         fill_word_ff <= fill_word_in;
         fill_resp_ff <= fill_resp_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      cell_ff      <= cell_in;
      req_ff       <= req_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      fill_word_in = fill_word_ff;
      fill_resp_in = fill_resp_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      cell_in      = cell_ff;
      req_in       = req_ff;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      // pending scroll copy beat writes by default
      mem_wr_en    = pend_ff;
      mem_wr_addr  = pend_addr_ff;
      mem_wr_data  = mem_rd_data;
      mem_rd_addr  = AW'(req_ff.read_address);

      unique case (state_ff)
         ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = fill_word_ff;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = fill_resp_ff ? ST_RESP : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               req_in   = req_item;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cell_in  = '0;
            state_in = ST_RESP;
            case (req_ff.command)
               CMD_PUT: begin
                  if (req_ff.char_code != CHAR_NUL) begin
                     if (req_ff.char_code != CHAR_NEWLINE) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = put_addr;
                        mem_wr_data = {text_attr, req_ff.char_code};
                     end
                     if (req_ff.char_code == CHAR_NEWLINE ||
                         col_ff == CW'(NUM_COLS - 1)) begin
                        col_in = '0;
                        if (row_ff == RW'(NUM_ROWS - 1)) begin
                           cnt_in   = '0;
                           state_in = ST_SCROLL;
                        end else begin
                           row_in = row_ff + RW'(1);
                        end
                     end else begin
                        col_in = col_ff + CW'(1);
                     end
                  end
               end
               CMD_CLEAR: begin
                  row_in       = '0;
                  col_in       = '0;
                  cnt_in       = '0;
                  fill_word_in = {blank_attr, CHAR_SPACE};
                  fill_resp_in = 1'b1;
                  state_in     = ST_FILL;
               end
               CMD_READ: begin
                  state_in = ST_READ;
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_SCROLL: begin
            if (32'(cnt_ff) < 32'(KEEP)) begin
               mem_rd_addr  = AW'(cnt_ff + AW'(NUM_COLS));
               pend_in      = 1'b1;
               pend_addr_in = cnt_ff;
               cnt_in       = cnt_ff + AW'(1);
            end else begin
               fill_word_in = {blank_attr, CHAR_SPACE};
               fill_resp_in = 1'b1;
               state_in     = ST_FILL;
            end
         end
         ST_READ: begin
            cell_in  = rd_in_range ? mem_rd_data : '0;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_item.cell_value = cell_ff;
   assign rsp_item.cursor_row = row_wide[4:0];
   assign rsp_item.cursor_col = col_wide[6:0];

endmodule

@@ rtl/text_console_cursor_scroll.sv @@
// text console top level: attribute registers, sequencer and cell store
//
// req channel: a command beat is taken at a clock edge with start high and busy
// low; busy stays high until the result beat has gone out.
// rsp channel: one beat per command, rsp_valid high for exactly one cycle; the
// receiver takes it in that cycle and cannot hold it off.
// csr channel: csr_ready is always high; index 0 is the text attribute, index 1
// the blank attribute. Write only while busy is low.
// Work per command (store of R rows by C columns):
//   plain put, newline without scroll, nul, unused code: at most one cell write
//   read: one registered read of the cell store
//   put that scrolls: (R-1)*C copy beats, then C fill beats, one copy or fill beat per cycle
//   clear: R*C blank cells, one blank cell per cycle
// The block returns to idle after each result beat, ready for the next accept.
// The cell store has a single write port and a single read port.
// After reset the store is filled with spaces, one cell per cycle with busy
// high; the cursor homes and the attributes take their reset values at once.
module text_console_cursor_scroll import ctsc_pkg::*; #(
   parameter int NUM_ROWS = DEF_NUM_ROWS,
   parameter int NUM_COLS = DEF_NUM_COLS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  req_item_type           req_item,
   output logic                   rsp_valid,
   output rsp_item_type           rsp_item,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   localparam int CELLS = NUM_ROWS * NUM_COLS;
   localparam int AW = $clog2(CELLS);

   logic [7:0]        text_attr_ff;
   logic [7:0]        blank_attr_ff;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [CELL_W-1:0] mem_wr_data;
   logic [AW-1:0]     mem_rd_addr;
   logic [CELL_W-1:0] mem_rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff  <= TEXT_ATTR_RESET;
         blank_attr_ff <= BLANK_ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_TEXT_ATTR:  text_attr_ff  <= csr_data;
            CSR_BLANK_ATTR: blank_attr_ff <= csr_data;
            default: ;
         endcase
      end
   end

   ctsc_ctrl #(
      .NUM_ROWS(NUM_ROWS),
      .NUM_COLS(NUM_COLS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .text_attr  (text_attr_ff),
      .blank_attr (blank_attr_ff),
      .mem_wr_en  (mem_wr_en),
      .mem_wr_addr(mem_wr_addr),
      .mem_wr_data(mem_wr_data),
      .mem_rd_addr(mem_rd_addr),
      .mem_rd_data(mem_rd_data)
   );

   ctsc_ram #(
      .DEPTH(CELLS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

endmodule

@@ rtl/ctsc_check.sv @@
// port-level checks of the text console, bound to the top level
module ctsc_check (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // a result beat only comes out of a command in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while not busy");

   // an accepted command keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accept");

   // one beat per command
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // the block is ready again right after the result beat
   a_ready_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("still busy after result beat");

endmodule

bind text_console_cursor_scroll ctsc_check u_ctsc_check (
   .clock    (clock),
   .reset    (reset),
   .start    (start),
   .busy     (busy),
   .rsp_valid(rsp_valid)
);
